### hw/rtl/double_ended_queue_top_assert.svh
// Assertion macros for the double-ended queue top level.
// Expects clk and arst_n in the scope of each use; no other dependencies.
`ifndef DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH

`ifndef SYNTH

// Consequent must hold in the same cycle as the antecedent.
`define DEQ_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deque check failed");

// Consequent must hold in the cycle after the antecedent.
`define DEQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deque check failed");

`else

`define DEQ_ASSERT_NOW(lbl, ante, cons)
`define DEQ_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### hw/rtl/deq_pkg.sv
// Shared types and constants for the double-ended queue.
// No dependencies; used by deq_ctrl and double_ended_queue_top.
`default_nettype none

package deq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int WORD_W    = 32;
	localparam int KIND_W    = 3;
	localparam int STATUS_W  = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_PUSH_FRONT = 3'd0,
		KIND_PUSH_BACK  = 3'd1,
		KIND_POP_FRONT  = 3'd2,
		KIND_POP_BACK   = 3'd3,
		KIND_DUMP       = 3'd4
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_DUMP = 1'b1
	} state_t;

	// Result descriptor waiting for the RAM read data
	typedef struct packed {
		status_t status;
		logic    use_data;
		logic    last;
	} s1_t;

endpackage

`default_nettype wire

### hw/rtl/deq_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/deq_ctrl.sv
// Queue controller: front pointer, fill count, dump sequencer and the entry RAM.
// Depends on deq_pkg and deq_ram.
`default_nettype none

module deq_ctrl #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [deq_pkg::KIND_W-1:0] kind,
	input  wire logic [deq_pkg::WORD_W-1:0] value,
	input  wire logic                       adv,
	output logic                            s1_valid,
	output deq_pkg::s1_t                    s1_info,
	output logic      [deq_pkg::WORD_W-1:0] rdata
);
	import deq_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = PTR_W + 1;

	state_t             state_q, state_d;
	logic [PTR_W-1:0]   front_q, front_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [PTR_W-1:0]   dump_idx_q, dump_idx_d;
	logic               s1_valid_q, s1_valid_d;
	s1_t                s1_q, s1_d;

	logic               go, dump_go, full, empty;
	logic [PTR_W-1:0]   front_dec, front_inc, back_slot, tail_slot, dump_slot;
	logic               dump_last;
	logic               ram_we, ram_re;
	logic [PTR_W-1:0]   ram_waddr, ram_raddr;

	function automatic logic [PTR_W-1:0] wrap_slot(input logic [PTR_W-1:0] base,
			input logic [SUM_W-1:0] off);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + off;
		if (sum >= SUM_W'(DEPTH)) begin
			sum = sum - SUM_W'(DEPTH);
		end
		return sum[PTR_W-1:0];
	endfunction

	assign in_ready = (state_q == S_IDLE) && (!s1_valid_q || adv);
	assign go       = in_valid && in_ready;
	assign dump_go  = (state_q == S_DUMP) && (!s1_valid_q || adv);

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	assign front_dec = (front_q == '0) ? PTR_W'(DEPTH - 1) : front_q - 1'b1;
	assign front_inc = (front_q == PTR_W'(DEPTH - 1)) ? '0 : front_q + 1'b1;
	assign back_slot = wrap_slot(front_q, SUM_W'(count_q));
	assign tail_slot = wrap_slot(front_q, SUM_W'(count_q) - SUM_W'(1));
	assign dump_slot = wrap_slot(front_q, SUM_W'(dump_idx_q));
	assign dump_last = (SUM_W'(dump_idx_q) + SUM_W'(1)) == SUM_W'(count_q);

	always_comb begin
		state_d    = state_q;
		front_d    = front_q;
		count_d    = count_q;
		dump_idx_d = dump_idx_q;
		s1_valid_d = s1_valid_q && !adv;
		s1_d       = s1_q;
		ram_we     = 1'b0;
		ram_waddr  = back_slot;
		ram_re     = 1'b0;
		ram_raddr  = front_q;

		if (go) begin
			s1_valid_d     = 1'b1;
			s1_d.status    = ST_OK;
			s1_d.use_data  = 1'b0;
			s1_d.last      = 1'b1;
			case (kind_t'(kind))
				KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
					if (full) begin
						s1_d.status = ST_FULL;
					end else begin
						ram_we  = 1'b1;
						count_d = count_q + 1'b1;
						if (kind_t'(kind) == KIND_PUSH_FRONT) begin
							ram_waddr = front_dec;
							front_d   = front_dec;
						end
					end
				end
				KIND_POP_FRONT, KIND_POP_BACK: begin
					if (empty) begin
						s1_d.status = ST_EMPTY;
					end else begin
						ram_re        = 1'b1;
						s1_d.use_data = 1'b1;
						count_d       = count_q - 1'b1;
						if (kind_t'(kind) == KIND_POP_FRONT) begin
							front_d = front_inc;
						end else begin
							ram_raddr = tail_slot;
						end
					end
				end
				KIND_DUMP: begin
					if (empty) begin
						s1_d.status = ST_EMPTY;
					end else begin
						// issue the front entry now, walk the rest afterwards
						ram_re        = 1'b1;
						s1_d.use_data = 1'b1;
						s1_d.last     = (count_q == CNT_W'(1));
						if (count_q != CNT_W'(1)) begin
							state_d    = S_DUMP;
							dump_idx_d = PTR_W'(1);
						end
					end
				end
				default: begin
					s1_valid_d = 1'b0;
				end
			endcase
		end else if (dump_go) begin
			ram_re        = 1'b1;
			ram_raddr     = dump_slot;
			s1_valid_d    = 1'b1;
			s1_d.status   = ST_OK;
			s1_d.use_data = 1'b1;
			s1_d.last     = dump_last;
			dump_idx_d    = dump_idx_q + 1'b1;
			if (dump_last) begin
				state_d = S_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			front_q    <= '0;
			count_q    <= '0;
			dump_idx_q <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			front_q    <= front_d;
			count_q    <= count_d;
			dump_idx_q <= dump_idx_d;
			s1_valid_q <= s1_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		s1_q <= s1_d;
	end

	deq_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(value),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rdata)
	);

	assign s1_valid = s1_valid_q;
	assign s1_info  = s1_q;

endmodule

`default_nettype wire

### hw/rtl/double_ended_queue_top.sv
// Top level of the bounded double-ended queue: stream ports and result register.
// Depends on deq_pkg, deq_ctrl (with deq_ram) and double_ended_queue_top_assert.svh.
//
// Channel   Direction  Payload (lowest bit first)
// s_axis    in         tdata: value[31:0]; tuser: kind[2:0]
// m_axis    out        tdata: value_res[31:0]; tuser: status[1:0]; tlast: last
//
// Back-to-back pushes and pops are taken every cycle while no dump runs and m_axis
// is not stalled. A result passes through the RAM read stage, then the output register.
// A dump holds s_axis_tready low until its last entry has been read, since each
// entry needs its own read on the single RAM port.
// Reset clears pointers and count at once; the entry RAM itself is never cleared.
// A stalled m_axis holds the output register and, behind it, the read stage.
`default_nettype none
`include "double_ended_queue_top_assert.svh"

module double_ended_queue_top #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	input  wire logic [deq_pkg::WORD_W-1:0]   s_axis_tdata,   // value
	input  wire logic [deq_pkg::KIND_W-1:0]   s_axis_tuser,   // kind
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	output logic      [deq_pkg::WORD_W-1:0]   m_axis_tdata,   // value_res
	output logic      [deq_pkg::STATUS_W-1:0] m_axis_tuser,   // status
	output logic                              m_axis_tlast
);
	import deq_pkg::*;

	logic               s1_valid;
	s1_t                s1_info;
	logic [WORD_W-1:0]  rdata;
	logic               adv;
	logic               pop_taken;

	logic               out_valid_q;
	logic [WORD_W-1:0]  out_data_q;
	status_t            out_status_q;
	logic               out_last_q;

	// Advance the read stage whenever the output register is free or being emptied
	assign adv = !out_valid_q || m_axis_tready;

	deq_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.kind    (s_axis_tuser),
		.value   (s_axis_tdata),
		.adv     (adv),
		.s1_valid(s1_valid),
		.s1_info (s1_info),
		.rdata   (rdata)
	);

	// Output register: valid flag under reset, payload loaded only on advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s1_valid) begin
			// drop the RAM word for status-only results
			out_data_q   <= s1_info.use_data ? rdata : '0;
			out_status_q <= s1_info.status;
			out_last_q   <= s1_info.last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tlast  = out_last_q;

	// Pop transaction taken on s_axis
	assign pop_taken = s_axis_tvalid && s_axis_tready &&
		(s_axis_tuser == KIND_POP_FRONT || s_axis_tuser == KIND_POP_BACK);

	// Status-only results (empty or full) always close their item
	`DEQ_ASSERT_NOW(a_status_only_last, s1_valid && s1_info.status != ST_OK, s1_info.last)
	// Input stays held while a dump still has entries to emit
	`DEQ_ASSERT_NOW(a_dump_blocks_input, s1_valid && !s1_info.last, !s_axis_tready)
	// A dump keeps the read stage filled until its final entry
	`DEQ_ASSERT_NEXT(a_dump_continues, s1_valid && !s1_info.last && adv, s1_valid)
	// Every accepted pop reaches the read stage in the next cycle
	`DEQ_ASSERT_NEXT(a_pop_result, pop_taken, s1_valid)

endmodule

`default_nettype wire

### sim/double_ended_queue_checker.sv
`timescale 1ns / 1ps
// Result checker for the double-ended queue: watches both stream channels,
// keeps a shadow copy of the queue and compares every result it sees.
// Depends on deq_pkg only.

module double_ended_queue_checker #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_axis_tvalid,
	input  wire logic                         s_axis_tready,
	input  wire logic [deq_pkg::WORD_W-1:0]   s_axis_tdata,   // value
	input  wire logic [deq_pkg::KIND_W-1:0]   s_axis_tuser,   // kind
	input  wire logic                         m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	input  wire logic [deq_pkg::WORD_W-1:0]   m_axis_tdata,   // value_res
	input  wire logic [deq_pkg::STATUS_W-1:0] m_axis_tuser,   // status
	input  wire logic                         m_axis_tlast,
	output int                                failures,
	output int                                pending
);
	import deq_pkg::*;

	typedef struct packed {
		status_t           status;
		logic [WORD_W-1:0] word;
		logic              last;
	} deq_result_t;

	logic [WORD_W-1:0] shadow_words [DEPTH];
	int                shadow_front;
	int                shadow_count;
	deq_result_t       awaited_results [$];

	function automatic void queue_result(status_t status, logic [WORD_W-1:0] word, logic last);
		deq_result_t r;
		r.status = status;
		r.word   = word;
		r.last   = last;
		awaited_results.push_back(r);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		deq_result_t want;
		int          slot;
		if (!arst_n) begin
			shadow_front = 0;
			shadow_count = 0;
			awaited_results.delete();
			failures = 0;
			pending  = 0;
		end else begin
			// compare the result first: nothing taken in this cycle can answer yet
			if (m_axis_tvalid && m_axis_tready) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, got status %0d value %h last %0d",
						$time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
					failures++;
				end else begin
					want = awaited_results.pop_front();
					if (m_axis_tuser !== want.status) begin
						$display("%0t: status mismatch, expected %0d, got %0d",
							$time, want.status, m_axis_tuser);
						failures++;
					end
					if (m_axis_tdata !== want.word) begin
						$display("%0t: value mismatch, expected %h, got %h",
							$time, want.word, m_axis_tdata);
						failures++;
					end
					if (m_axis_tlast !== want.last) begin
						$display("%0t: last mismatch, expected %0d, got %0d",
							$time, want.last, m_axis_tlast);
						failures++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				case (s_axis_tuser)
					KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
						if (shadow_count >= DEPTH) begin
							queue_result(ST_FULL, '0, 1'b1);
						end else begin
							if (s_axis_tuser == KIND_PUSH_FRONT) begin
								shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
								shadow_words[shadow_front] = s_axis_tdata;
							end else begin
								shadow_words[(shadow_front + shadow_count) % DEPTH] = s_axis_tdata;
							end
							shadow_count++;
							queue_result(ST_OK, '0, 1'b1);
						end
					end
					KIND_POP_FRONT, KIND_POP_BACK: begin
						if (shadow_count == 0) begin
							queue_result(ST_EMPTY, '0, 1'b1);
						end else begin
							if (s_axis_tuser == KIND_POP_FRONT) begin
								slot = shadow_front;
								shadow_front = (shadow_front + 1) % DEPTH;
							end else begin
								slot = (shadow_front + shadow_count - 1) % DEPTH;
							end
							shadow_count--;
							queue_result(ST_OK, shadow_words[slot], 1'b1);
						end
					end
					KIND_DUMP: begin
						if (shadow_count == 0) begin
							queue_result(ST_EMPTY, '0, 1'b1);
						end else begin
							for (int i = 0; i < shadow_count; i++)
								queue_result(ST_OK, shadow_words[(shadow_front + i) % DEPTH],
									i == shadow_count - 1);
						end
					end
					default: begin
						// spare codes: no result, no change
					end
				endcase
			end
			pending = awaited_results.size();
		end
	end

endmodule

### sim/double_ended_queue_top_test.sv
`timescale 1ns / 1ps
// Testbench top for the double-ended queue: clock, reset, stimulus and verdict.
// Depends on deq_pkg, double_ended_queue_top and double_ended_queue_checker.

module double_ended_queue_top_test;
	import deq_pkg::*;

	localparam int DEPTH       = DEPTH_DEF;
	localparam int RANDOM_OPS  = 290;
	localparam int MAX_WAIT    = 12;   // longest gap or stall per transaction
	localparam int STALL_LIMIT = 2000; // cycles without any transaction
	localparam int DRAIN_WAIT  = 8;    // settle time after the last result

	// codes the block must ignore
	localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
	localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

	// operation mixes for the random runs
	localparam int MIX_FILL  = 0;
	localparam int MIX_DRAIN = 1;
	localparam int MIX_EVEN  = 2;

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [WORD_W-1:0]   s_axis_tdata;   // value
	logic [KIND_W-1:0]   s_axis_tuser;   // kind
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [WORD_W-1:0]   m_axis_tdata;   // value_res
	logic [STATUS_W-1:0] m_axis_tuser;   // status
	logic                m_axis_tlast;

	int chk_failures;
	int chk_pending;
	int send_burst;  // transactions still to send back to back

	double_ended_queue_top #(
		.DEPTH(DEPTH)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	double_ended_queue_checker #(
		.DEPTH(DEPTH)
	) checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.failures     (chk_failures),
		.pending      (chk_pending)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Mostly random words, with the extremes mixed in often.
	function automatic logic [WORD_W-1:0] draw_word();
		case ($urandom_range(0, 15))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return 32'h0000_0000;
			3:       return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// Offer one transaction on s_axis and hold it until it is taken.
	// Called at a rising edge; returns at the edge that accepts the transaction.
	task automatic send_item(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] word);
		int   gap;
		logic seen;
		if (send_burst > 0) begin
			gap = 0;
			send_burst--;
		end else begin
			gap = $urandom_range(0, MAX_WAIT);
			if ($urandom_range(0, 15) == 0)
				send_burst = $urandom_range(8, 30);
		end
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= word;
		s_axis_tuser  <= kind;
		// sample ready mid-cycle, away from the edge where it may change
		do begin
			@(negedge clk);
			seen = s_axis_tready;
			@(posedge clk);
		end while (!seen);
	endtask

	// Receiver: draw a stall before each result, with stall-free stretches now and then.
	initial begin
		int   stall;
		int   recv_burst;
		logic seen;
		recv_burst    = 0;
		m_axis_tready = 1'b0;
		@(posedge clk);
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			if (recv_burst > 0) begin
				stall = 0;
				recv_burst--;
			end else begin
				stall = $urandom_range(0, MAX_WAIT);
				if ($urandom_range(0, 15) == 0)
					recv_burst = $urandom_range(8, 30);
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do begin
				@(negedge clk);
				seen = m_axis_tvalid;
				@(posedge clk);
			end while (!seen);
		end
	end

	// Watchdog: end the run if no transaction moves on either side for too long.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		@(posedge clk);
		while (arst_n !== 1'b1) @(posedge clk);
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
		$display("status: fail");
		$finish;
	end

	initial begin
		int                ops_sent;
		int                run_len;
		int                mix;
		int                pick;
		logic [KIND_W-1:0] op;

		// drive every input to a known value from the start
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		send_burst    = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty cases first, then extremes, wrap-around and a full queue.
		send_item(KIND_POP_FRONT, draw_word());
		send_item(KIND_POP_BACK, draw_word());
		send_item(KIND_DUMP, draw_word());
		send_item(KIND_PUSH_FRONT, 32'h7fff_ffff);   // front index wraps below zero
		send_item(KIND_PUSH_BACK, 32'h8000_0000);
		send_item(KIND_PUSH_FRONT, 32'hffff_ffff);
		send_item(KIND_PUSH_BACK, 32'h0000_0000);
		send_item(KIND_DUMP, draw_word());
		send_item(KIND_POP_FRONT, draw_word());
		send_item(KIND_POP_BACK, draw_word());
		send_item(KIND_SPARE_FIRST, draw_word());
		send_item(KIND_SPARE_LAST, draw_word());
		// fill to capacity from both ends, then try both pushes on a full queue
		for (int i = 2; i < DEPTH; i++)
			send_item(i[0] ? KIND_PUSH_FRONT : KIND_PUSH_BACK, draw_word());
		send_item(KIND_PUSH_FRONT, draw_word());
		send_item(KIND_PUSH_BACK, draw_word());
		send_item(KIND_DUMP, draw_word());

		// Random part: runs that lean towards filling, draining or neither,
		// so full and empty are reached again and again.
		ops_sent = 0;
		while (ops_sent < RANDOM_OPS) begin
			run_len = $urandom_range(10, 30);
			mix     = $urandom_range(MIX_FILL, MIX_EVEN);
			repeat (run_len) begin
				if ($urandom_range(0, 99) < 3) begin
					// noise on the spare codes; does not count as an operation
					send_item(3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST)), draw_word());
				end else begin
					pick = $urandom_range(0, 99);
					case (mix)
						MIX_FILL:  op = (pick < 78) ? KIND_PUSH_FRONT :
						                (pick < 95) ? KIND_POP_FRONT : KIND_DUMP;
						MIX_DRAIN: op = (pick < 78) ? KIND_POP_FRONT :
						                (pick < 95) ? KIND_PUSH_FRONT : KIND_DUMP;
						default:   op = (pick < 45) ? KIND_PUSH_FRONT :
						                (pick < 90) ? KIND_POP_FRONT : KIND_DUMP;
					endcase
					// pick the end of the queue at random
					if (op != KIND_DUMP && $urandom_range(0, 1))
						op = (op == KIND_PUSH_FRONT) ? KIND_PUSH_BACK : KIND_POP_BACK;
					send_item(op, draw_word());
					ops_sent++;
				end
			end
		end

		// drop valid and wait for every outstanding result; let the checker
		// take in the last transaction before its count is read
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (chk_pending != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (chk_failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/deq_pkg.sv
hw/rtl/deq_ram.sv
hw/rtl/deq_ctrl.sv
hw/rtl/double_ended_queue_top.sv
sim/double_ended_queue_checker.sv
sim/double_ended_queue_top_test.sv
